// ----- sv/sm3_pkg.sv -----
// package with sm3 types, constants and step functions
`timescale 1ns / 1ps
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;

	localparam logic [255:0] SM3_IV =
		256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;

	// one block word handed from the front to the back
	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  pos;
		logic        fin;
	} sm3_cmd_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_EMIT
	} sm3_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm_p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm_p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

// ----- sv/sm3_stream_if.sv -----
// valid/ready stream interface carrying a word and a flag
`timescale 1ns / 1ps
interface sm3_stream_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	logic        flag;

	modport source (output valid, output data, output flag, input ready);
	modport sink (input valid, input data, input flag, output ready);
endinterface

// ----- sv/sm3_front.sv -----
// front end: tracks word position, pads partial blocks, feeds the queue
`timescale 1ns / 1ps
module sm3_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     in_word,
	input  logic            in_final,
	output logic            q_valid,
	input  logic            q_ready,
	output sm3_pkg::sm3_cmd_t q_cmd
);
	import sm3_pkg::*;

	logic [3:0] pos_q;
	logic       pad_q;

	// while padding, zero words are produced until position fifteen
	assign in_ready = !pad_q && q_ready;
	assign q_valid  = pad_q || in_valid;

	always_comb begin
		q_cmd.pos = pos_q;
		if (pad_q) begin
			q_cmd.word = '0;
			q_cmd.fin  = (pos_q == 4'd15);
		end else begin
			q_cmd.word = in_word;
			q_cmd.fin  = in_final && (pos_q == 4'd15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pad_q <= 1'b0;
		end else if (q_valid && q_ready) begin
			pos_q <= pos_q + 4'd1;
			if (pad_q) begin
				if (pos_q == 4'd15) pad_q <= 1'b0;
			end else if (in_final && pos_q != 4'd15) begin
				pad_q <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> !in_ready) else $error("input taken during padding");
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && q_cmd.fin) |=> (pos_q == 4'd0 && !pad_q))
		else $error("final word did not close the block");
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> (pos_q == $past(pos_q) + 4'd1))
		else $error("position did not advance");
endmodule

// ----- sv/sm3_queue.sv -----
// two-entry queue between front and back
`timescale 1ns / 1ps
module sm3_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  sm3_pkg::sm3_cmd_t wr_cmd,
	output logic            rd_valid,
	input  logic            rd_ready,
	output sm3_pkg::sm3_cmd_t rd_cmd
);
	import sm3_pkg::*;

	sm3_cmd_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_cmd   = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= !wp_q;
			if (rd_en) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q == rp_q) |-> (cnt_q == 2'd0 || cnt_q == 2'd2))
		else $error("queue pointers inconsistent");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count wrong");
endmodule

// ----- sv/sm3_back.sv -----
// back end: block buffer, expansion window, 64 rounds, chaining and digest output
`timescale 1ns / 1ps
module sm3_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  sm3_pkg::sm3_cmd_t q_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     out_word,
	output logic            out_last
);
	import sm3_pkg::*;

	sm3_state_t  state_q, state_d;
	logic [31:0] w_q [16];      // sliding window w[j..j+15]
	logic [31:0] r_q [8];
	logic [31:0] cv_q [8];
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  emit_q;
	logic [31:0] w_new, tj, a12, ss1, ss2, ff, gg, tt1, tt2, wp;
	logic        early, take, round_go, emit_go, round_end;

	assign take  = q_valid && q_ready;
	assign early = (rnd_q < 6'd16);
	assign w_new = perm_p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
		^ rotl(w_q[3], 5'd7) ^ w_q[10];
	assign wp    = w_q[0] ^ w_q[4];
	assign tj    = early ? T_LOW : T_HIGH;
	assign a12   = rotl(r_q[0], 5'd12);
	assign ss1   = rotl(a12 + r_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
	assign ss2   = ss1 ^ a12;
	assign ff    = early ? (r_q[0] ^ r_q[1] ^ r_q[2])
		: ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]));
	assign gg    = early ? (r_q[4] ^ r_q[5] ^ r_q[6])
		: ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]));
	assign tt1   = ff + r_q[3] + ss2 + wp;
	assign tt2   = gg + r_q[7] + ss1 + w_q[0];
	assign round_end = (rnd_q == 6'd63);
	assign out_word  = cv_q[emit_q];
	assign out_last  = (emit_q == 3'd7);

	always_comb begin
		state_d   = state_q;
		q_ready   = 1'b0;
		out_valid = 1'b0;
		round_go  = 1'b0;
		emit_go   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				q_ready = 1'b1;
				if (q_valid && q_cmd.pos == 4'd15) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				round_go = 1'b1;
				if (round_end) state_d = fin_q ? ST_EMIT : ST_LOAD;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				emit_go   = out_ready;
				if (out_ready && emit_q == 3'd7) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// chaining value and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= SM3_IV[255 - 32*i -: 32];
			rnd_q  <= '0;
			emit_q <= '0;
			fin_q  <= 1'b0;
		end else begin
			if (take && q_cmd.pos == 4'd15) begin
				fin_q <= q_cmd.fin;
				rnd_q <= '0;
			end
			if (round_go) begin
				rnd_q <= rnd_q + 6'd1;
				if (round_end) begin
					cv_q[0] <= cv_q[0] ^ tt1;
					cv_q[1] <= cv_q[1] ^ r_q[0];
					cv_q[2] <= cv_q[2] ^ rotl(r_q[1], 5'd9);
					cv_q[3] <= cv_q[3] ^ r_q[2];
					cv_q[4] <= cv_q[4] ^ perm_p0(tt2);
					cv_q[5] <= cv_q[5] ^ r_q[4];
					cv_q[6] <= cv_q[6] ^ rotl(r_q[5], 5'd19);
					cv_q[7] <= cv_q[7] ^ r_q[6];
				end
			end
			if (emit_go) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7)
					for (int i = 0; i < 8; i++) cv_q[i] <= SM3_IV[255 - 32*i -: 32];
			end
		end
	end

	// block buffer doubles as expansion window, round registers
	always_ff @(posedge clk) begin
		if (take) w_q[q_cmd.pos] <= q_cmd.word;
		if (take && q_cmd.pos == 4'd15)
			for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
		if (round_go) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			r_q[0] <= tt1;
			r_q[1] <= r_q[0];
			r_q[2] <= rotl(r_q[1], 5'd9);
			r_q[3] <= r_q[2];
			r_q[4] <= perm_p0(tt2);
			r_q[5] <= r_q[4];
			r_q[6] <= rotl(r_q[5], 5'd19);
			r_q[7] <= r_q[6];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_end && !fin_q) |=> state_q == ST_LOAD)
		else $error("no return to load after block");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EMIT) |-> emit_q == 3'd0) else $error("emit index stray");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !q_ready) else $error("queue read while busy");
endmodule

// ----- sv/sm3_hash_core_unit.sv -----
// top level of the sm3 hash engine
`timescale 1ns / 1ps
//  channel  | dir | word fields
//  msg      | in  | data = message_word, flag = final_word
//  dig      | out | data = digest_word,  flag = digest_last
//
// a block of 16 words is loaded and then compressed in 64 rounds, one round per cycle
// the final word adds a zero-padding flush of the rest of the block and the
// output of the 8 digest words
// reset restores the iv in the chaining registers at once; no clearing pass
// the front pads and queues words while the back compresses; a stalled digest
// holds the back, and the front keeps filling the queue until it is full
module sm3_hash_core_unit (
	input  logic          clk,
	input  logic          arst_n,
	sm3_stream_if.sink    msg,
	sm3_stream_if.source  dig
);
	import sm3_pkg::*;

	// front to queue
	logic     fq_valid, fq_ready;
	sm3_cmd_t fq_cmd;
	// queue to back
	logic     qb_valid, qb_ready;
	sm3_cmd_t qb_cmd;

	sm3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (msg.valid),
		.in_ready (msg.ready),
		.in_word  (msg.data),
		.in_final (msg.flag),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_cmd    (fq_cmd)
	);

	sm3_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_cmd   (fq_cmd),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_cmd   (qb_cmd)
	);

	sm3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_cmd     (qb_cmd),
		.out_valid (dig.valid),
		.out_ready (dig.ready),
		.out_word  (dig.data),
		.out_last  (dig.flag)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(dig.valid && !dig.ready) |=> dig.valid) else $error("digest word dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(dig.valid && !dig.ready) |=> $stable(dig.data)) else $error("digest word changed");
endmodule

// ----- tb/sm3_tb_scoreboard.sv -----
// scoreboard class: sm3 digest predictor and expected digest word store
`timescale 1ns / 1ps
package sm3_tb_scoreboard_pkg;
	import sm3_pkg::*;

	typedef struct {
		logic [31:0] word;
		logic        last;
	} digest_item_t;

	class sm3_digest_board;
		logic [31:0] chain [8];
		logic [31:0] blk [16];
		int unsigned pos;
		digest_item_t pending [$];
		int unsigned errors;

		function new();
			reset_state();
			errors = 0;
		endfunction

		function void reset_state();
			for (int i = 0; i < 8; i++)
				chain[i] = SM3_IV[255 - 32 * i -: 32];
			pos = 0;
		endfunction

		static function logic [31:0] rol(logic [31:0] x, int n);
			n = n % 32;
			if (n == 0)
				return x;
			return (x << n) | (x >> (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [68];
			logic [31:0] r [8];
			logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
			for (int j = 0; j < 16; j++)
				w[j] = blk[j];
			for (int j = 16; j < 68; j++) begin
				t = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
				t = t ^ rol(t, 15) ^ rol(t, 23);
				w[j] = t ^ rol(w[j-13], 7) ^ w[j-6];
			end
			for (int i = 0; i < 8; i++)
				r[i] = chain[i];
			for (int j = 0; j < 64; j++) begin
				t = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
				a12 = rol(r[0], 12);
				ss1 = rol(a12 + r[4] + rol(t, j % 32), 7);
				ss2 = ss1 ^ a12;
				ff = (j < 16) ? (r[0] ^ r[1] ^ r[2])
					: ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
				gg = (j < 16) ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
				tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
				tt2 = gg + r[7] + ss1 + w[j];
				r[3] = r[2];
				r[2] = rol(r[1], 9);
				r[1] = r[0];
				r[0] = tt1;
				r[7] = r[6];
				r[6] = rol(r[5], 19);
				r[5] = r[4];
				r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
			end
			for (int i = 0; i < 8; i++)
				chain[i] ^= r[i];
		endfunction

		// note one accepted message word
		function void note_word(logic [31:0] word, logic fin);
			digest_item_t d;
			blk[pos] = word;
			if (!fin) begin
				if (pos == 15) begin
					compress();
					pos = 0;
				end else
					pos++;
				return;
			end
			for (int k = pos + 1; k < 16; k++)
				blk[k] = '0;
			compress();
			for (int k = 0; k < 8; k++) begin
				d.word = chain[k];
				d.last = (k == 7);
				pending.push_back(d);
			end
			reset_state();
		endfunction

		// check one accepted digest word
		function void check_digest(logic [31:0] word, logic last);
			digest_item_t d;
			if (pending.size() == 0) begin
				$display("%0t: unexpected digest word %h last %b", $time, word, last);
				errors++;
				return;
			end
			d = pending.pop_front();
			if (word !== d.word) begin
				$display("%0t: digest_word expected %h actual %h", $time, d.word, word);
				errors++;
			end
			if (last !== d.last) begin
				$display("%0t: digest_last expected %b actual %b", $time, d.last, last);
				errors++;
			end
		endfunction
	endclass
endpackage

// ----- tb/tb_sm3_hash_core_unit.sv -----
// testbench top for the sm3 hash engine
`timescale 1ns / 1ps
module tb_sm3_hash_core_unit;
	import sm3_tb_scoreboard_pkg::*;

	logic clk;
	logic arst_n;
	sm3_stream_if msg ();
	sm3_stream_if dig ();

	sm3_hash_core_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.dig(dig)
	);

	sm3_digest_board board;
	int unsigned idle_cycles;
	int unsigned word_count;
	bit long_hold;
	bit hold_done;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// sender: sticky valid, new word only after acceptance
	task automatic send_word(logic [31:0] w, logic fin);
		msg.data <= w;
		msg.flag <= fin;
		msg.valid <= 1'b1;
		do
			@(posedge clk);
		while (!msg.ready);
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		msg.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// bursts of random length with random gaps
	int unsigned burst_left;
	task automatic send_paced(logic [31:0] w, logic fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 12));
		end
		burst_left--;
		send_word(w, fin);
	endtask

	// message of n words, last one marks final
	task automatic send_message(int n, bit paced);
		logic [31:0] w;
		for (int i = 0; i < n; i++) begin
			w = $urandom();
			case ($urandom_range(0, 7))
				0: w = '0;
				1: w = '1;
				default: ;
			endcase
			if (paced)
				send_paced(w, i == n - 1);
			else
				send_word(w, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		msg.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	// accept-side bookkeeping at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg.valid && msg.ready) begin
				board.note_word(msg.data, msg.flag);
				word_count++;
			end
			if (dig.valid && dig.ready)
				board.check_digest(dig.data, dig.flag);
		end
	end

	// receiver: stall pattern plus one long hold-off
	initial begin
		int unsigned phase;
		phase = 0;
		dig.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				dig.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_done = 1'b1;
			end
			phase++;
			// runs of free flow alternate with choppy stretches
			if ((phase / 64) % 3 == 0)
				dig.ready <= 1'b1;
			else
				dig.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((msg.valid && msg.ready) || (dig.valid && dig.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		board = new();
		idle_cycles = 0;
		word_count = 0;
		burst_left = 0;
		long_hold = 1'b0;
		hold_done = 1'b0;
		arst_n = 1'b0;
		msg.valid = 1'b0;
		msg.data = '0;
		msg.flag = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: one-word messages of all zeros and all ones, a full sixteen-word block, block boundary cases
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h6162_6380, 1'b0);
		for (int i = 1; i < 15; i++)
			send_word(32'h0, 1'b0);
		send_word(32'h0000_0018, 1'b1);
		send_message(16, 1'b0);
		send_message(17, 1'b0);
		// sender pauses until every digest word has come
		wait_drained();

		// long receiver hold while messages keep coming so the input stalls
		long_hold = 1'b1;
		send_message(32, 1'b0);
		send_message(20, 1'b0);
		send_message(3, 1'b0);
		wait_drained();

		// random messages, mostly short, some multi-block
		while (word_count < 470) begin
			case ($urandom_range(0, 5))
				0: n = 16;
				1: n = 32 + $urandom_range(0, 16);
				default: n = $urandom_range(1, 15);
			endcase
			send_message(n, 1'b1);
		end
		wait_drained();
		repeat (200) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
